### rtl/bresenham_line_rasterizer_core_defines.svh
// Assertion macros used by the back end of the line rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define BLR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/blr_pkg.sv
// Shared types and constants of the line rasterizer.
package blr_pkg;

  // Direction flags of one line, decided by the front end.
  typedef struct packed {
    logic x_major;  // x advances on every cell
    logic x_neg;    // x steps toward smaller values
    logic y_neg;    // y steps toward smaller values
  } blr_dir_t;

  // Extra bits of the error term beyond the coordinate width.
  localparam int unsigned ERR_GUARD = 3;

  // Entries of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

### rtl/blr_front.sv
// Front end: accepts line requests and sets up the stepping terms.
module blr_front
  import blr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                 push,
  input  logic                                 q_full,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         end_x,
  input  logic signed [COORD_BITS-1:0]         end_y,
  output logic                                 q_push,
  output logic        [COORD_BITS-1:0]         q_x0,
  output logic        [COORD_BITS-1:0]         q_y0,
  output logic        [COORD_BITS-1:0]         q_major,
  output logic        [COORD_BITS-1:0]         q_minor,
  output logic signed [COORD_BITS+ERR_GUARD-1:0] q_err,
  output blr_dir_t                             q_dir
);

  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic        [COORD_BITS:0]   dx_abs;
  logic        [COORD_BITS:0]   dy_abs;
  logic        [COORD_BITS-1:0] ax;
  logic        [COORD_BITS-1:0] ay;
  logic                         x_major;

  always_comb begin
    dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    dx_abs = dx[COORD_BITS] ? -dx : dx;
    dy_abs = dy[COORD_BITS] ? -dy : dy;
    ax = dx_abs[COORD_BITS-1:0];
    ay = dy_abs[COORD_BITS-1:0];
    // Ties go to the y axis.
    x_major = ax > ay;

    q_major = x_major ? ax : ay;
    q_minor = x_major ? ay : ax;
    q_err = $signed({2'b00, q_minor, 1'b0}) - $signed({3'b000, q_major});

    q_dir.x_major = x_major;
    q_dir.x_neg   = dx[COORD_BITS] | (dx == '0);
    q_dir.y_neg   = dy[COORD_BITS] | (dy == '0);

    q_x0 = start_x;
    q_y0 = start_y;

    // Drop zero-length requests here: they produce no cells.
    q_push = push && !q_full && (q_major != '0);
  end

endmodule

### rtl/blr_queue.sv
// Small FIFO of prepared lines between front and back end.
module blr_queue
  import blr_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CW'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/blr_back.sv
// Back end: steps along one line per cell and holds the result register.
module blr_back
  import blr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  output logic                                   q_pop,
  input  logic        [COORD_BITS-1:0]           q_x0,
  input  logic        [COORD_BITS-1:0]           q_y0,
  input  logic        [COORD_BITS-1:0]           q_major,
  input  logic        [COORD_BITS-1:0]           q_minor,
  input  logic signed [COORD_BITS+ERR_GUARD-1:0] q_err,
  input  blr_dir_t                               q_dir,
  input  logic                                   pop,
  output logic                                   empty,
  output logic signed [COORD_BITS-1:0]           pixel_x,
  output logic signed [COORD_BITS-1:0]           pixel_y,
  output logic                                   last_pixel
);

`include "bresenham_line_rasterizer_core_defines.svh"

  localparam int unsigned EW = COORD_BITS + ERR_GUARD;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bk_state_t;

  bk_state_t                state;
  logic [COORD_BITS-1:0]    cx;
  logic [COORD_BITS-1:0]    cy;
  logic signed [EW-1:0]     err;
  logic signed [EW-1:0]     min2;
  logic signed [EW-1:0]     delta;
  logic [COORD_BITS-1:0]    remain;
  blr_dir_t                 dir;
  logic                     ovalid;

  logic                     out_free;
  logic                     load;
  logic                     emit;
  logic                     err_pos;
  logic                     last;
  logic                     step_x;
  logic                     step_y;
  logic signed [EW-1:0]     err_next;
  logic [COORD_BITS-1:0]    cx_next;
  logic [COORD_BITS-1:0]    cy_next;

  always_comb begin
    out_free = !ovalid || pop;
    load     = (state == ST_IDLE) && !q_empty;
    emit     = (state == ST_RUN) && out_free;
    err_pos  = !err[EW-1];
    last     = remain == COORD_BITS'(1);
    step_x   = dir.x_major || err_pos;
    step_y   = !dir.x_major || err_pos;
    err_next = err + (err_pos ? delta : min2);
    cx_next  = step_x ? (dir.x_neg ? cx - COORD_BITS'(1) : cx + COORD_BITS'(1)) : cx;
    cy_next  = step_y ? (dir.y_neg ? cy - COORD_BITS'(1) : cy + COORD_BITS'(1)) : cy;
  end

  assign q_pop = load;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (load) begin
            cx     <= q_x0;
            cy     <= q_y0;
            err    <= q_err;
            min2   <= $signed({2'b00, q_minor, 1'b0});
            delta  <= $signed({2'b00, q_minor, 1'b0}) - $signed({2'b00, q_major, 1'b0});
            remain <= q_major;
            dir    <= q_dir;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            pixel_x    <= cx;
            pixel_y    <= cy;
            last_pixel <= last;
            cx         <= cx_next;
            cy         <= cy_next;
            err        <= err_next;
            remain     <= remain - COORD_BITS'(1);
            if (last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BLR_ASSERT_ALWAYS(a_run_has_cells, !(state == ST_RUN && remain == '0), "running with no cells left")
  `BLR_ASSERT_NEXT(a_last_ends_run, emit && last, state == ST_IDLE, "run did not end on last cell")
  `BLR_ASSERT_NEXT(a_load_nonempty, load, state == ST_RUN && remain != '0, "zero-length line loaded")
  `BLR_ASSERT_NEXT(a_emit_fills_out, emit, !empty, "emitted cell not presented")

endmodule

### rtl/bresenham_line_rasterizer_core.sv
// Top level of the Bresenham line rasterizer.
//
// Usage:
//   Request side is a queue write port: present start_x/start_y/end_x/end_y
//   with push high; the request is taken on a clock edge where full is low.
//   Result side is a queue read port: while empty is low, pixel_x, pixel_y
//   and last_pixel show the oldest cell; pop high on an edge takes it.
//   Cells of a line come out in order from the start point, stopping one
//   cell short of the end point; last_pixel marks the final cell. A request
//   with equal endpoints yields nothing.
// Timing:
//   A taken request waits in the queue until the stepper is idle and loads
//   it; the first cell of the line then fills the output register. The
//   stepper produces one cell per cycle while that register is free, and a
//   line has N cells (N = major-axis distance, at most 2^COORD_BITS - 1).
//   A two-entry queue lets requests be taken while a line is still drawn.
// Reset (rst, synchronous) empties the queue and the output register.
// Stall: with pop low the output register holds its cell and the stepper
//   waits; once the queue fills, full rises and requests are held off.
module bresenham_line_rasterizer_core
  import blr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  localparam int unsigned EW = COORD_BITS + ERR_GUARD;
  // Queue entry: x0, y0, major, minor, initial error, direction flags.
  localparam int unsigned QW = 4 * COORD_BITS + EW + $bits(blr_dir_t);

  logic                  f_push;
  logic [COORD_BITS-1:0] f_x0;
  logic [COORD_BITS-1:0] f_y0;
  logic [COORD_BITS-1:0] f_major;
  logic [COORD_BITS-1:0] f_minor;
  logic signed [EW-1:0]  f_err;
  blr_dir_t              f_dir;

  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [QW-1:0]         q_rd;

  logic [COORD_BITS-1:0] b_x0;
  logic [COORD_BITS-1:0] b_y0;
  logic [COORD_BITS-1:0] b_major;
  logic [COORD_BITS-1:0] b_minor;
  logic signed [EW-1:0]  b_err;
  blr_dir_t              b_dir;

  // Hold off requests only when the queue has no room.
  assign full = q_full;

  // Classify the request and set up the error term.
  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .push    (push),
    .q_full  (q_full),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .q_push  (f_push),
    .q_x0    (f_x0),
    .q_y0    (f_y0),
    .q_major (f_major),
    .q_minor (f_minor),
    .q_err   (f_err),
    .q_dir   (f_dir)
  );

  // Decouple setup from stepping.
  blr_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data ({f_x0, f_y0, f_major, f_minor, f_err, f_dir}),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {b_x0, b_y0, b_major, b_minor, b_err, b_dir} = q_rd;

  // Step along the line, one cell per cycle into the output register while it is free.
  blr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_x0       (b_x0),
    .q_y0       (b_y0),
    .q_major    (b_major),
    .q_minor    (b_minor),
    .q_err      (b_err),
    .q_dir      (b_dir),
    .pop        (pop),
    .empty      (empty),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule

### test/bresenham_line_checker.sv
// Checker for the line rasterizer: predicts each line's cells and compares them.
module bresenham_line_checker #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [COORD_BITS-1:0] pixel_x,
  input  logic signed [COORD_BITS-1:0] pixel_y,
  input  logic                         last_pixel,
  output int                           mismatches,
  output int                           cells_pending,
  output int                           lines_taken,
  output int                           cells_checked
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } cell_t;

  cell_t expected_cells[$];
  cell_t want;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Walk one line and queue every cell it covers, end point excluded.
  task automatic plot_line(input coord_t x0, input coord_t y0, input coord_t x1,
                           input coord_t y1);
    int   dx, dy, ax, ay, step_x, step_y, major, minor, err, cx, cy;
    bit   x_major;
    cell_t c;
    dx = int'(x1) - int'(x0);
    dy = int'(y1) - int'(y0);
    step_x = (dx > 0) ? 1 : -1;
    step_y = (dy > 0) ? 1 : -1;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    x_major = ax > ay;
    major = x_major ? ax : ay;
    minor = x_major ? ay : ax;
    err = 2 * minor - major;
    cx = int'(x0);
    cy = int'(y0);
    for (int k = 0; k < major; k++) begin
      c.x = coord_t'(cx);
      c.y = coord_t'(cy);
      c.last = (k == major - 1);
      expected_cells.push_back(c);
      if (err >= 0) begin
        if (x_major) cy += step_y;
        else cx += step_x;
        err -= 2 * major;
      end
      err += 2 * minor;
      if (x_major) cx += step_x;
      else cy += step_y;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_cells.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("cell (%0d,%0d) last=%0b with no line pending",
                                    pixel_x, pixel_y, last_pixel));
        end else begin
          want = expected_cells[0];
          expected_cells.delete(0);
          cells_checked++;
          if (pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", pixel_x, want.x));
          if (pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d", pixel_y, want.y));
          if (last_pixel !== want.last)
            report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                      last_pixel, want.last, want.x, want.y));
        end
      end
      if (push && !full) begin
        plot_line(start_x, start_y, end_x, end_y);
        lines_taken++;
      end
    end
    cells_pending = expected_cells.size();
  end

endmodule

### test/tb.sv
// Top of the line rasterizer testbench: clock, reset, stimulus and verdict.
module tb;

  localparam int unsigned COORD_BITS = 6;
  localparam int HOLD_CYCLES = 400;      // long output hold-off to fill the block
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES = 100;      // longest line plus pipeline, with margin
  localparam int RANDOM_LINES = 80;      // random requests per pacing mode

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   pop = 1'b0;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;

  wire         full;
  wire         empty;
  wire coord_t pixel_x;
  wire coord_t pixel_y;
  wire         last_pixel;

  int mismatches;
  int cells_pending;
  int lines_taken;
  int cells_checked;

  // Pacing knobs, in percent per cycle.
  int sender_idle_pct = 0;
  int stall_pct = 0;

  // Long hold-off: the stimulus bumps hold_req, the receiver serves it.
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  always #1 clk = ~clk;

  bresenham_line_rasterizer_core #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .empty     (empty),
    .pop       (pop),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_pixel(last_pixel)
  );

  bresenham_line_checker #(
    .COORD_BITS(COORD_BITS)
  ) line_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .empty        (empty),
    .pop          (pop),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_pixel   (last_pixel),
    .mismatches   (mismatches),
    .cells_pending(cells_pending),
    .lines_taken  (lines_taken),
    .cells_checked(cells_checked)
  );

  // Receiver: drive pop once per edge. A pending hold request takes
  // precedence and keeps pop low for the whole hold-off, counted down in hold_left.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      pop <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count edges where neither side moves anything; give up at the limit.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d cells still pending",
               quiet_cycles, cells_pending);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v < -32) return -32;
    if (v > 31) return 31;
    return v;
  endfunction

  // Offer one request and hold it until the block takes it. Then idle for a
  // random gap drawn per cycle; with no gap, leave push high for the next one.
  task automatic send_line(input int x0, input int y0, input int x1, input int y1);
    int gap;
    start_x <= coord_t'(x0);
    start_y <= coord_t'(y0);
    end_x <= coord_t'(x1);
    end_y <= coord_t'(y1);
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = 0;
    while (gap < 200 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Build one random request. Mix degenerate, short, axis-aligned and
  // diagonal lines with fully random ones so every branch of the stepper
  // gets exercised, not just long shallow lines.
  task automatic send_random_line();
    int x0, y0, x1, y1, kind, span;
    kind = $urandom_range(99);
    x0 = int'($urandom_range(63)) - 32;
    y0 = int'($urandom_range(63)) - 32;
    x1 = int'($urandom_range(63)) - 32;
    y1 = int'($urandom_range(63)) - 32;
    if (kind < 8) begin
      // equal endpoints: no cells
      x1 = x0;
      y1 = y0;
    end else if (kind < 32) begin
      // short line near the start
      x1 = clamp_coord(x0 + int'($urandom_range(8)) - 4);
      y1 = clamp_coord(y0 + int'($urandom_range(8)) - 4);
    end else if (kind < 42) begin
      // zero minor delta
      if ($urandom_range(1)) x1 = x0;
      else y1 = y0;
    end else if (kind < 52) begin
      // equal |dx| and |dy|, where y must win the major axis
      span = (x1 > x0) ? x1 - x0 : x0 - x1;
      if (y0 + span <= 31 && (y0 - span < -32 || $urandom_range(1))) y1 = y0 + span;
      else if (y0 - span >= -32) y1 = y0 - span;
    end else if (kind < 58) begin
      // |dx| one more than |dy|: x just barely major
      span = int'($urandom_range(30));
      x1 = clamp_coord(x0 + span + 1);
      y1 = clamp_coord(y0 - span);
      if (x1 - x0 != span + 1 || y0 - y1 != span) begin
        x0 = -32;
        y0 = 31;
        x1 = x0 + span + 1;
        y1 = y0 - span;
      end
    end
    send_line(x0, y0, x1, y1);
  endtask

  initial begin
    // Hold reset, then release it for good.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: degenerate, axis-aligned at full span, diagonals,
    // shallow and steep in three of four quadrants, and the shortest lines.
    send_line(0, 0, 0, 0);
    send_line(-32, -32, -32, -32);
    send_line(-32, 0, 31, 0);
    send_line(31, 5, -32, 5);
    send_line(3, -32, 3, 31);
    send_line(-7, 31, -7, -32);
    send_line(-32, -32, 31, 31);
    send_line(31, -32, -32, 31);
    send_line(31, 31, -32, -32);
    send_line(-32, 31, 31, -32);
    send_line(0, 0, 10, 3);
    send_line(0, 0, -10, -3);
    send_line(5, 5, -20, 12);
    send_line(0, 0, 3, 10);
    send_line(0, 0, -3, -10);
    send_line(0, 0, 5, 4);
    send_line(-32, -32, 31, 30);
    send_line(0, 0, 1, 0);
    send_line(0, 0, 0, -1);
    send_line(0, 0, 1, 1);
    send_line(0, 0, 2, 1);
    send_line(0, 0, -1, 2);

    // Back-pressure: hold off the receiver for a long stretch and keep
    // offering long lines so the request queue fills and full rises.
    hold_req <= hold_req + 1;
    for (int k = 0; k < 6; k++) begin
      send_line(-32, k * 10 - 30, 31, 25 - k * 9);
    end

    // Random requests under each pacing mode: none, sender idle,
    // receiver stalling, then both.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          sender_idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      repeat (RANDOM_LINES) send_random_line();
    end

    // Drop push, let the checker take in the last request, drain every
    // expected cell, then watch a quiet tail for stray cells. The watchdog
    // catches a drain that never completes.
    push <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d line requests and checked %0d cells under four pacing modes,",
             lines_taken, cells_checked);
    $display("with a long output hold-off that filled the block; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && cells_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/blr_pkg.sv
rtl/blr_front.sv
rtl/blr_queue.sv
rtl/blr_back.sv
rtl/bresenham_line_rasterizer_core.sv
test/bresenham_line_checker.sv
test/tb.sv
